// ===== rtl/core/sfoa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfoa_pkg
// Shared types, codes and constants of the section frame owner allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfoa_pkg;

	localparam int PHYS_SECTIONS_DEF = 512;
	localparam int ASID_BITS_DEF     = 8;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 80;

	localparam int SECTION_SHIFT = 20;
	localparam int DESC_AP_SHIFT = 10;
	localparam int DESC_NG_SHIFT = 17;
	localparam logic [1:0] DESC_TAG = 2'b10;
	localparam logic [1:0] DESC_AP  = 2'b11;

	typedef enum logic [1:0] {
		CMD_MAP_FIXED = 2'd0,
		CMD_ALLOC     = 2'd1,
		CMD_RELEASE   = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_OWNED = 2'd1;
	localparam logic [1:0] STATUS_NOMEM = 2'd2;

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_RESP
	} state_t;

	function automatic logic [31:0] make_desc(input logic [11:0] pa, input logic ng);
		logic [31:0] d;
		d = 32'(DESC_TAG) | (32'(DESC_AP) << DESC_AP_SHIFT)
			| (32'(ng) << DESC_NG_SHIFT) | {pa, 20'b0};
		return d;
	endfunction

	function automatic logic [31:0] make_sync(input logic [11:0] va, input logic [7:0] asid);
		logic [31:0] w;
		w = {va, 20'b0} | 32'(asid);
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfoa_ram.sv =====
// ----------------------------------------------------------------------------
// sfoa_ram
// Generic simple dual port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sfoa_ram #(
	parameter int WIDTH = sfoa_pkg::ASID_BITS_DEF,
	parameter int DEPTH = sfoa_pkg::PHYS_SECTIONS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/section_frame_owner_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// section_frame_owner_allocator_unit
// Owner table of physical sections: map fixed, first fit allocate, release
// and clear, each request answered by one response.
// ----------------------------------------------------------------------------
// flow: release and map fixed that records no owner answer from idle,
//   recording map fixed reads the owner in a lookup state, allocate scans
//   from section 1 to the first free one (one table entry read per cycle)
// throughput: one request at a time, next request taken after the response
// reset and clear: the table is swept to zero, no request is taken during
//   the sweep; only clear answers when the sweep ends
`default_nettype none

module section_frame_owner_allocator_unit #(
	parameter int PHYS_SECTIONS = sfoa_pkg::PHYS_SECTIONS_DEF,
	parameter int ASID_BITS     = sfoa_pkg::ASID_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// va_section, pa_section, asid, global_flag, shared_flag, sync_flag,
	// entry_tag, entry_not_global, entry_base, zero fill
	input  wire logic [sfoa_pkg::IN_TDATA_W-1:0]    s_tdata,
	// command
	input  wire logic [1:0]                         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// descriptor, entry_index, sync_request, sync_word, zero fill
	output logic      [sfoa_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// status
	output logic      [1:0]                         m_tuser
);

	localparam int AW = $clog2(PHYS_SECTIONS);
	localparam logic [AW-1:0] LAST = AW'(PHYS_SECTIONS - 1);
	localparam logic [12:0] LIMIT = 13'(PHYS_SECTIONS);

	sfoa_pkg::state_t state_q, state_nxt;
	sfoa_pkg::cmd_t   in_cmd;

	logic [11:0] in_va, in_pa, in_base;
	logic [ASID_BITS-1:0] in_asid;
	logic in_global, in_shared, in_sync, in_eng;
	logic [1:0] in_etag;
	logic accept, recordable, releasable;

	logic [11:0] va_q, pa_q;
	logic [ASID_BITS-1:0] asid_q;
	logic sync_q;
	logic [AW-1:0] chk_q, wipe_q;
	logic wipe_resp_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [ASID_BITS-1:0] wdata, rdata;

	logic resp_load;
	logic [1:0] resp_status;
	logic [31:0] resp_desc, resp_sword;
	logic [11:0] resp_idx;
	logic resp_sreq;

	logic out_valid_q;
	logic [1:0] status_q;
	logic [31:0] desc_q, sword_q;
	logic [11:0] idx_q;
	logic sreq_q;

	assign in_cmd    = sfoa_pkg::cmd_t'(s_tuser);
	assign in_va     = s_tdata[11:0];
	assign in_pa     = s_tdata[23:12];
	assign in_asid   = s_tdata[24 +: ASID_BITS];
	assign in_global = s_tdata[32];
	assign in_shared = s_tdata[33];
	assign in_sync   = s_tdata[34];
	assign in_etag   = s_tdata[36:35];
	assign in_eng    = s_tdata[37];
	assign in_base   = s_tdata[49:38];

	assign s_tready   = (state_q == sfoa_pkg::ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign recordable = !in_global && !in_shared && ({1'b0, in_pa} < LIMIT);
	assign releasable = (in_etag != 2'b00) && in_eng && ({1'b0, in_base} < LIMIT);

	sfoa_ram #(
		.WIDTH(ASID_BITS),
		.DEPTH(PHYS_SECTIONS)
	) u_owner_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sfoa_pkg::ST_WIPE: begin
				if (wipe_q == LAST) begin
					state_nxt = wipe_resp_q ? sfoa_pkg::ST_RESP : sfoa_pkg::ST_IDLE;
				end
			end
			sfoa_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						sfoa_pkg::CMD_MAP_FIXED:
							state_nxt = recordable ? sfoa_pkg::ST_LOOK : sfoa_pkg::ST_RESP;
						sfoa_pkg::CMD_ALLOC:   state_nxt = sfoa_pkg::ST_SCAN;
						sfoa_pkg::CMD_RELEASE: state_nxt = sfoa_pkg::ST_RESP;
						sfoa_pkg::CMD_CLEAR:   state_nxt = sfoa_pkg::ST_WIPE;
						default:               state_nxt = sfoa_pkg::ST_IDLE;
					endcase
				end
			end
			sfoa_pkg::ST_LOOK: state_nxt = sfoa_pkg::ST_RESP;
			sfoa_pkg::ST_SCAN: begin
				if (rdata == '0 || chk_q == LAST) begin
					state_nxt = sfoa_pkg::ST_RESP;
				end
			end
			sfoa_pkg::ST_RESP: begin
				if (m_tready) begin
					state_nxt = sfoa_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sfoa_pkg::ST_WIPE;
		endcase
	end

	// table access and response
	always_comb begin
		we          = 1'b0;
		waddr       = wipe_q;
		wdata       = '0;
		raddr       = chk_q + AW'(1);
		resp_load   = 1'b0;
		resp_status = sfoa_pkg::STATUS_OK;
		resp_desc   = '0;
		resp_idx    = '0;
		resp_sreq   = 1'b0;
		resp_sword  = '0;
		case (state_q)
			sfoa_pkg::ST_WIPE: begin
				we        = 1'b1;
				resp_load = (wipe_q == LAST) && wipe_resp_q;
			end
			sfoa_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						sfoa_pkg::CMD_MAP_FIXED: begin
							raddr = in_pa[AW-1:0];
							if (!recordable) begin
								resp_load  = 1'b1;
								resp_desc  = sfoa_pkg::make_desc(in_pa, !in_global);
								resp_idx   = in_va;
								resp_sreq  = in_sync;
								resp_sword = in_sync ?
									sfoa_pkg::make_sync(in_va, 8'(in_asid)) : '0;
							end
						end
						sfoa_pkg::CMD_ALLOC: begin
							raddr = AW'(1);
						end
						sfoa_pkg::CMD_RELEASE: begin
							we        = releasable;
							waddr     = in_base[AW-1:0];
							resp_load = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			sfoa_pkg::ST_LOOK: begin
				resp_load = 1'b1;
				if (rdata != '0) begin
					resp_status = sfoa_pkg::STATUS_OWNED;
				end else begin
					we         = 1'b1;
					waddr      = pa_q[AW-1:0];
					wdata      = asid_q;
					resp_desc  = sfoa_pkg::make_desc(pa_q, 1'b1);
					resp_idx   = va_q;
					resp_sreq  = sync_q;
					resp_sword = sync_q ? sfoa_pkg::make_sync(va_q, 8'(asid_q)) : '0;
				end
			end
			sfoa_pkg::ST_SCAN: begin
				if (rdata == '0) begin
					we         = 1'b1;
					waddr      = chk_q;
					wdata      = asid_q;
					resp_load  = 1'b1;
					resp_desc  = sfoa_pkg::make_desc(12'(chk_q), 1'b1);
					resp_idx   = va_q;
					resp_sreq  = sync_q;
					resp_sword = sync_q ? sfoa_pkg::make_sync(va_q, 8'(asid_q)) : '0;
				end else if (chk_q == LAST) begin
					resp_load   = 1'b1;
					resp_status = sfoa_pkg::STATUS_NOMEM;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfoa_pkg::ST_WIPE;
			wipe_q      <= '0;
			wipe_resp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == sfoa_pkg::ST_WIPE) begin
				wipe_q <= wipe_q + AW'(1);
			end else if (accept && in_cmd == sfoa_pkg::CMD_CLEAR) begin
				wipe_q      <= '0;
				wipe_resp_q <= 1'b1;
			end
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request fields and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			va_q   <= in_va;
			pa_q   <= in_pa;
			asid_q <= in_asid;
			sync_q <= in_sync;
			chk_q  <= AW'(1);
		end else if (state_q == sfoa_pkg::ST_SCAN) begin
			chk_q <= chk_q + AW'(1);
		end
		if (resp_load) begin
			status_q <= resp_status;
			desc_q   <= resp_desc;
			idx_q    <= resp_idx;
			sreq_q   <= resp_sreq;
			sword_q  <= resp_sword;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, sword_q, sreq_q, idx_q, desc_q};

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("request taken while a response is pending");

	a_nomem_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == sfoa_pkg::STATUS_NOMEM) |-> (m_tdata == '0))
		else $error("out of memory response carries data");

	a_owned_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == sfoa_pkg::STATUS_OWNED) |-> (m_tdata == '0))
		else $error("owned response carries data");

	a_scan_skips_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfoa_pkg::ST_SCAN) |-> (chk_q != '0))
		else $error("scan reached section zero");

	a_resp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfoa_pkg::ST_RESP) |-> m_tvalid)
		else $error("response state without a valid response");

endmodule

`default_nettype wire

// ===== tb/sv/section_frame_owner_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_frame_owner_allocator_unit_test
// Drives map fixed, allocate, release and clear requests into the owner
// table through the stream ports and checks each response field by field
// against a mirror of the table kept here. A short table of hand-picked
// requests comes first, followed by random traffic, a run that fills the
// table to out of memory, and churn on the full table. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------

module section_frame_owner_allocator_unit_test;

	import sfoa_pkg::*;

	localparam int PHYS        = PHYS_SECTIONS_DEF;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		cmd_t        cmd;
		logic [11:0] va;
		logic [11:0] pa;
		logic [7:0]  asid;
		logic        glb;
		logic        shr;
		logic        sync;
		logic [1:0]  etag;
		logic        eng;
		logic [11:0] ebase;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] descriptor;
		logic [11:0] entry_index;
		logic        sync_request;
		logic [31:0] sync_word;
	} answer_t;

	typedef struct packed {
		bit      pinned;
		answer_t want;
	} pin_t;

	typedef struct {
		req_t    req;
		bit      pinned;
		answer_t want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	logic [7:0]  owner_mirror [PHYS];
	answer_t     owed_answers [$];
	pin_t        pinned_answers [$];
	dir_row_t    dir_rows [$];
	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	int unsigned stall_left;
	int unsigned rx_mode;

	section_frame_owner_allocator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic req_t mk_req(input cmd_t c, input logic [11:0] va, input logic [11:0] pa,
			input logic [7:0] asid, input logic glb, input logic shr, input logic sync,
			input logic [1:0] etag, input logic eng, input logic [11:0] ebase);
		req_t r;
		r = '{c, va, pa, asid, glb, shr, sync, etag, eng, ebase};
		return r;
	endfunction

	function automatic answer_t mk_answer(input logic [1:0] status, input logic [31:0] desc,
			input logic [11:0] idx, input logic sreq, input logic [31:0] sword);
		answer_t a;
		a = '{status, desc, idx, sreq, sword};
		return a;
	endfunction

	// updates the owner mirror and returns the response the request earns
	function automatic answer_t apply_to_owner_table(input req_t r);
		answer_t     a;
		int          idx;
		logic [11:0] sec;
		logic        ng;
		bit          emits;
		a = '0;
		emits = 1'b0;
		sec = '0;
		ng = 1'b0;
		case (r.cmd)
			CMD_MAP_FIXED: begin
				if (!r.glb && !r.shr && r.pa < PHYS) begin
					if (owner_mirror[r.pa] != 8'd0) begin
						a.status = STATUS_OWNED;
						return a;
					end
					owner_mirror[r.pa] = r.asid;
				end
				sec = r.pa;
				ng = !r.glb;
				emits = 1'b1;
			end
			CMD_ALLOC: begin
				idx = 1;
				while (idx < PHYS && owner_mirror[idx] != 8'd0)
					idx++;
				if (idx >= PHYS) begin
					a.status = STATUS_NOMEM;
					return a;
				end
				owner_mirror[idx] = r.asid;
				sec = 12'(idx);
				ng = 1'b1;
				emits = 1'b1;
			end
			CMD_RELEASE: begin
				if (r.etag != 2'd0 && r.eng && r.ebase < PHYS)
					owner_mirror[r.ebase] = 8'd0;
			end
			default: begin
				foreach (owner_mirror[i])
					owner_mirror[i] = 8'd0;
			end
		endcase
		if (emits) begin
			a.status = STATUS_OK;
			a.descriptor = {sec, 20'b0} | (32'(ng) << DESC_NG_SHIFT)
				| (32'(DESC_AP) << DESC_AP_SHIFT) | 32'(DESC_TAG);
			a.entry_index = r.va;
			if (r.sync) begin
				a.sync_request = 1'b1;
				a.sync_word = {r.va, 20'b0} | 32'(r.asid);
			end
		end
		return a;
	endfunction

	function automatic req_t gen_req(input cmd_t c);
		req_t r;
		int   pick;
		r.cmd = c;
		r.va = 12'($urandom);
		r.pa = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, PHYS - 1));
		r.asid = 8'($urandom);
		r.glb = ($urandom_range(0, 3) == 0);
		r.shr = ($urandom_range(0, 3) == 0);
		r.sync = 1'($urandom_range(0, 1));
		r.etag = 2'($urandom);
		r.eng = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 9);
		if (pick < 5)
			r.ebase = 12'($urandom_range(0, 63));
		else if (pick < 8)
			r.ebase = 12'($urandom_range(0, PHYS - 1));
		else
			r.ebase = 12'($urandom);
		if (c == CMD_RELEASE && $urandom_range(0, 4) != 0)
			r.etag = 2'($urandom_range(1, 3));
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic push_req(input req_t r, input bit pinned, input answer_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		pinned_answers.push_back('{pinned, want});
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, r.ebase, r.eng, r.etag, r.sync, r.shr, r.glb, r.asid, r.pa, r.va};
		s_tuser <= r.cmd;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (owed_answers.size() != 0)
			@(posedge clk);
	endtask

	// request and response monitor
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		req_t    r;
		pin_t    pin;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.descriptor = m_tdata[31:0];
				got.entry_index = m_tdata[43:32];
				got.sync_request = m_tdata[44];
				got.sync_word = m_tdata[76:45];
				if (owed_answers.size() == 0) begin
					$error("response with no request pending");
					fail_count++;
				end else begin
					want = owed_answers.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("descriptor", want.descriptor, got.descriptor);
					check_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
					check_field("sync_request", 32'(want.sync_request), 32'(got.sync_request));
					check_field("sync_word", want.sync_word, got.sync_word);
				end
			end
			if (s_tvalid && s_tready) begin
				r.cmd = cmd_t'(s_tuser);
				{r.ebase, r.eng, r.etag, r.sync, r.shr, r.glb, r.asid, r.pa, r.va} =
					s_tdata[49:0];
				want = apply_to_owner_table(r);
				pin = pinned_answers.pop_front();
				if (pin.pinned)
					want = pin.want;
				owed_answers.push_back(want);
			end
		end
	end

	// response side back pressure
	always @(posedge clk) begin
		if (cycle_count % 300 == 0)
			rx_mode = $urandom_range(0, 2);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			case (rx_mode)
				1: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 3);
				2: if ($urandom_range(0, 3) != 0) stall_left = $urandom_range(2, 6);
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("section_frame_owner_allocator_unit_test NOT OK");
			$finish;
		end
	end

	initial begin
		answer_t none;
		req_t    r;
		int      pick;
		none = mk_answer(STATUS_OK, 32'd0, 12'd0, 1'b0, 32'd0);
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		burst_left = 0;
		stall_left = 0;
		rx_mode = 0;
		foreach (owner_mirror[i])
			owner_mirror[i] = 8'd0;

		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h000, 12'h000, 8'hFF,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b1,
			mk_answer(STATUS_OK, 32'h00020C02, 12'h000, 1'b1, 32'h000000FF)});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h005, 12'h000, 8'h01,
			0, 0, 1, 2'd3, 1, 12'hFFF), 1'b1,
			mk_answer(STATUS_OWNED, 32'd0, 12'd0, 1'b0, 32'd0)});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'hFFF, 12'hFFF, 8'hAA,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b1,
			mk_answer(STATUS_OK, 32'hFFF20C02, 12'hFFF, 1'b1, 32'hFFF000AA)});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h001, 12'h000, 8'h02,
			1, 0, 0, 2'd0, 0, 12'h000), 1'b1,
			mk_answer(STATUS_OK, 32'h00000C02, 12'h001, 1'b0, 32'd0)});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h002, 12'h000, 8'h10,
			0, 1, 1, 2'd0, 0, 12'h000), 1'b1,
			mk_answer(STATUS_OK, 32'h00020C02, 12'h002, 1'b1, 32'h00200010)});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_ALLOC, 12'h007, 12'h123, 8'h05,
			1, 1, 1, 2'd0, 0, 12'h000), 1'b1,
			mk_answer(STATUS_OK, 32'h00120C02, 12'h007, 1'b1, 32'h00700005)});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_ALLOC, 12'h008, 12'h000, 8'h00,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_ALLOC, 12'h009, 12'h000, 8'h03,
			0, 0, 0, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_RELEASE, 12'h000, 12'h000, 8'h00,
			0, 0, 0, 2'd0, 1, 12'h001), 1'b1, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_RELEASE, 12'h000, 12'h000, 8'h00,
			0, 0, 0, 2'd1, 0, 12'h001), 1'b1, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_RELEASE, 12'h000, 12'h000, 8'h00,
			0, 0, 0, 2'd3, 1, 12'h001), 1'b1, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_RELEASE, 12'h000, 12'h000, 8'h00,
			0, 0, 0, 2'd2, 1, 12'hFFF), 1'b1, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_ALLOC, 12'h0AB, 12'h000, 8'h09,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h003, 12'(PHYS - 1), 8'h80,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h004, 12'(PHYS), 8'h81,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h005, 12'h003, 8'h00,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h006, 12'h003, 8'h04,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_CLEAR, 12'hFFF, 12'hFFF, 8'hFF,
			1, 1, 1, 2'd3, 1, 12'hFFF), 1'b1, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'h000, 12'h000, 8'h01,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_MAP_FIXED, 12'hFFF, 12'h000, 8'hFF,
			0, 0, 0, 2'd0, 0, 12'h000), 1'b0, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_RELEASE, 12'h000, 12'h000, 8'h00,
			0, 0, 0, 2'd2, 1, 12'h000), 1'b1, none});
		dir_rows.push_back(dir_row_t'{mk_req(CMD_ALLOC, 12'h010, 12'h000, 8'h11,
			0, 0, 1, 2'd0, 0, 12'h000), 1'b0, none});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			push_req(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].want);

		// mixed traffic with frequent clears
		for (int n = 0; n < 520; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				r = gen_req(CMD_MAP_FIXED);
			else if (pick < 65)
				r = gen_req(CMD_ALLOC);
			else if (pick < 92)
				r = gen_req(CMD_RELEASE);
			else
				r = gen_req(CMD_CLEAR);
			push_req(r, 1'b0, none);
		end

		// hold off until the table is quiet, then fill it to out of memory
		drain();
		for (int n = 0; n < 515; n++) begin
			r = gen_req(($urandom_range(0, 7) == 0) ? CMD_MAP_FIXED : CMD_ALLOC);
			r.asid = 8'($urandom_range(1, 255));
			push_req(r, 1'b0, none);
		end

		// churn on a full table
		for (int n = 0; n < 110; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				r = gen_req(CMD_RELEASE);
				r.ebase = 12'($urandom_range(0, PHYS - 1));
			end else if (pick < 8) begin
				r = gen_req(CMD_ALLOC);
			end else begin
				r = gen_req(CMD_MAP_FIXED);
			end
			push_req(r, 1'b0, none);
		end
		push_req(gen_req(CMD_CLEAR), 1'b0, none);

		drain();
		repeat (PHYS + 8) @(posedge clk);
		if (fail_count == 0)
			$display("section_frame_owner_allocator_unit_test OK");
		else
			$display("section_frame_owner_allocator_unit_test NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sfoa_pkg.sv
rtl/core/sfoa_ram.sv
rtl/core/section_frame_owner_allocator_unit.sv
tb/sv/section_frame_owner_allocator_unit_test.sv
